// ===== src/sle_pkg.sv =====
// shared types, register indexes and reset values for the stall lock escalation block
// no dependencies
package sle_pkg;

  localparam int unsigned ShortWinW = 16;
  localparam int unsigned LongWinW  = 17;
  localparam int unsigned HoldW     = 16;
  localparam int unsigned CntW      = 4;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 17;

  localparam logic [ShortWinW-1:0] ShortWinRst = ShortWinW'(6000);
  localparam logic [LongWinW-1:0]  LongWinRst  = LongWinW'(90000);
  localparam logic [HoldW-1:0]     HoldRst     = HoldW'(12000);
  localparam logic [CntW-1:0]      StallLimRst = CntW'(3);
  localparam logic [CntW-1:0]      LockLimRst  = CntW'(3);
  localparam logic [CntW-1:0]      CntMax      = {CntW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SHORT_WIN  = 3'd0,
    CFG_LONG_WIN   = 3'd1,
    CFG_HOLD       = 3'd2,
    CFG_STALL_LIM  = 3'd3,
    CFG_LOCK_LIM   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [ShortWinW-1:0] short_win;
    logic [LongWinW-1:0]  long_win;
    logic [HoldW-1:0]     hold;
    logic [CntW-1:0]      stall_lim;
    logic [CntW-1:0]      lock_lim;
  } cfg_t;

  typedef struct packed {
    logic            lock;
    logic            perm;
    logic [CntW-1:0] stall_events;
    logic [CntW-1:0] lock_events;
  } res_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v == CntMax) ? CntMax : v + CntW'(1);
  endfunction

endpackage

// ===== src/sle_cfg_regs.sv =====
// configuration register file for the stall lock escalation block
// depends on sle_pkg
module sle_cfg_regs import sle_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SHORT_WIN: cfg_d.short_win = cfg_data_i[ShortWinW-1:0];
        CFG_LONG_WIN:  cfg_d.long_win  = cfg_data_i[LongWinW-1:0];
        CFG_HOLD:      cfg_d.hold      = cfg_data_i[HoldW-1:0];
        CFG_STALL_LIM: cfg_d.stall_lim = cfg_data_i[CntW-1:0];
        CFG_LOCK_LIM:  cfg_d.lock_lim  = cfg_data_i[CntW-1:0];
        default:       cfg_d           = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_win <= ShortWinRst;
      cfg_q.long_win  <= LongWinRst;
      cfg_q.hold      <= HoldRst;
      cfg_q.stall_lim <= StallLimRst;
      cfg_q.lock_lim  <= LockLimRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== src/sle_core.sv =====
// tick update: edge detect, window timers, lock and permanent escalation
// depends on sle_pkg
module sle_core import sle_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic step_i,
  input  logic stall_i,
  output res_t res_o
);

  logic                 prev_q, prev_d;
  logic [CntW-1:0]      stall_cnt_q, stall_cnt_d;
  logic [CntW-1:0]      lock_cnt_q, lock_cnt_d;
  logic [ShortWinW-1:0] short_tmr_q, short_tmr_d;
  logic [LongWinW-1:0]  long_tmr_q, long_tmr_d;
  logic [HoldW-1:0]     hold_tmr_q, hold_tmr_d;
  logic                 flag_q, flag_d;
  logic                 perm_now;

  assign perm_now = (lock_cnt_q >= cfg_i.lock_lim);

  always_comb begin
    prev_d      = prev_q;
    stall_cnt_d = stall_cnt_q;
    lock_cnt_d  = lock_cnt_q;
    short_tmr_d = short_tmr_q;
    long_tmr_d  = long_tmr_q;
    hold_tmr_d  = hold_tmr_q;
    flag_d      = flag_q;
    if (perm_now) begin
      // permanent: everything but the flag stays frozen
      flag_d = 1'b1;
    end else begin
      if (stall_i && !prev_q) begin
        if (stall_cnt_q == '0) short_tmr_d = cfg_i.short_win;
        stall_cnt_d = sat_inc(stall_cnt_q);
      end
      prev_d = stall_i;

      if (short_tmr_d != '0) short_tmr_d = short_tmr_d - ShortWinW'(1);
      else                   stall_cnt_d = '0;

      if (stall_cnt_d >= cfg_i.stall_lim) begin
        if (lock_cnt_q == '0) long_tmr_d = cfg_i.long_win;
        lock_cnt_d  = sat_inc(lock_cnt_q);
        hold_tmr_d  = cfg_i.hold;
        flag_d      = 1'b1;
        stall_cnt_d = '0;
        short_tmr_d = '0;
      end

      if (hold_tmr_d != '0)                  hold_tmr_d = hold_tmr_d - HoldW'(1);
      else if (lock_cnt_d < cfg_i.lock_lim) flag_d     = 1'b0;

      if (long_tmr_d != '0)                  long_tmr_d = long_tmr_d - LongWinW'(1);
      else if (lock_cnt_d < cfg_i.lock_lim) lock_cnt_d = '0;
    end
  end

  assign res_o.lock         = flag_d;
  assign res_o.perm         = (lock_cnt_d >= cfg_i.lock_lim);
  assign res_o.stall_events = stall_cnt_d;
  assign res_o.lock_events  = lock_cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= 1'b0;
      stall_cnt_q <= '0;
      lock_cnt_q  <= '0;
      short_tmr_q <= '0;
      long_tmr_q  <= '0;
      hold_tmr_q  <= '0;
      flag_q      <= 1'b0;
    end else if (step_i) begin
      prev_q      <= prev_d;
      stall_cnt_q <= stall_cnt_d;
      lock_cnt_q  <= lock_cnt_d;
      short_tmr_q <= short_tmr_d;
      long_tmr_q  <= long_tmr_d;
      hold_tmr_q  <= hold_tmr_d;
      flag_q      <= flag_d;
    end
  end

  // a permanent lock always shows the lock flag
  a_perm_locks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |-> (!res_o.perm || res_o.lock))
    else $error("permanent without lock flag");

  // once permanent, edge memory and counters are frozen
  a_perm_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && perm_now) |=> ($stable(prev_q) && $stable(stall_cnt_q)
                              && $stable(lock_cnt_q)))
    else $error("state moved while permanent");

  // a new lock event with a non-zero hold time raises the flag
  a_lock_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !perm_now && (lock_cnt_d != lock_cnt_q) && (lock_cnt_d != '0)
     && (cfg_i.hold != '0))
      |=> flag_q)
    else $error("lock event without flag");

endmodule

// ===== src/stall_lock_escalation.sv =====
// top level: input register, tick update core, result register, config registers
// depends on sle_pkg, sle_cfg_regs, sle_core
// a word accepted into the input register moves on to the result register once that
// register is free, and is shown on the outputs from there
// throughput: one word per cycle; the result register frees the input side each
// cycle the result is taken or the output is empty
// reset: all counters, timers and flags clear; config registers load their defaults
module stall_lock_escalation import sle_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                stall_active_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                lock_out_o,
  output logic                permanent_out_o,
  output logic [CntW-1:0]     stall_events_o,
  output logic [CntW-1:0]     lock_events_o
);

  cfg_t cfg;
  res_t res;
  res_t out_q;
  logic in_v_q, in_stall_q;
  logic out_v_q;
  logic out_free, step;

  sle_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign out_free   = !out_v_q || out_ready_i;
  assign step       = in_v_q && out_free;
  assign in_ready_o = !in_v_q || out_free;

  sle_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .step_i  (step),
    .stall_i (in_stall_q),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_ready_o) in_v_q  <= in_valid_i;
      if (out_free)   out_v_q <= in_v_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_stall_q <= stall_active_i;
    if (step)                     out_q      <= res;
  end

  assign out_valid_o     = out_v_q;
  assign lock_out_o      = out_q.lock;
  assign permanent_out_o = out_q.perm;
  assign stall_events_o  = out_q.stall_events;
  assign lock_events_o   = out_q.lock_events;

  // a word in the input stage waits while the result word is not taken
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_v_q && !out_free) |=> (in_v_q && $stable(in_stall_q)))
    else $error("input word lost under stall");

  // every processed word appears as a result
  a_step_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_v_q)
    else $error("processed word not shown");

  // a result word waiting for the receiver stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_ready_i) |=> (out_v_q && $stable(out_q)))
    else $error("result word changed while waiting");

endmodule

// ===== tb/sle_checker.sv =====
`timescale 1ns / 100ps
// checker for stall_lock_escalation: watches the config, tick and result channels,
// mirrors the tick update and compares every result word; depends on sle_pkg
module sle_checker import sle_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                stall_active_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic                lock_out_i,
  input  logic                permanent_out_i,
  input  logic [CntW-1:0]     stall_events_i,
  input  logic [CntW-1:0]     lock_events_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  cfg_t                 cfg;
  logic                 prev_stall;
  logic [CntW-1:0]      stall_cnt;
  logic [CntW-1:0]      lock_cnt;
  logic [ShortWinW-1:0] short_tmr;
  logic [LongWinW-1:0]  long_tmr;
  logic [HoldW-1:0]     hold_tmr;
  logic                 lock_flag;
  res_t                 tick_results_q[$];
  int unsigned          fails;

  function automatic logic [CntW-1:0] bump(input logic [CntW-1:0] v);
    return (v == CntMax) ? v : v + CntW'(1);
  endfunction

  // one tick of the escalation logic; updates the mirrored state in place
  function automatic res_t advance_tick(input logic stall);
    res_t r;
    if (lock_cnt >= cfg.lock_lim) begin
      // permanent: everything frozen, flag forced on
      lock_flag = 1'b1;
    end else begin
      if (stall && !prev_stall) begin
        if (stall_cnt == '0) short_tmr = cfg.short_win;
        stall_cnt = bump(stall_cnt);
      end
      prev_stall = stall;

      if (short_tmr != '0) short_tmr = short_tmr - ShortWinW'(1);
      else stall_cnt = '0;

      if (stall_cnt >= cfg.stall_lim) begin
        if (lock_cnt == '0) long_tmr = cfg.long_win;
        lock_cnt  = bump(lock_cnt);
        hold_tmr  = cfg.hold;
        lock_flag = 1'b1;
        stall_cnt = '0;
        short_tmr = '0;
      end

      if (hold_tmr != '0) hold_tmr = hold_tmr - HoldW'(1);
      else if (lock_cnt < cfg.lock_lim) lock_flag = 1'b0;

      if (long_tmr != '0) long_tmr = long_tmr - LongWinW'(1);
      else if (lock_cnt < cfg.lock_lim) lock_cnt = '0;
    end
    r.lock         = lock_flag;
    r.perm         = (lock_cnt >= cfg.lock_lim);
    r.stall_events = stall_cnt;
    r.lock_events  = lock_cnt;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      cfg.short_win = ShortWinRst;
      cfg.long_win  = LongWinRst;
      cfg.hold      = HoldRst;
      cfg.stall_lim = StallLimRst;
      cfg.lock_lim  = LockLimRst;
      prev_stall    = 1'b0;
      stall_cnt     = '0;
      lock_cnt      = '0;
      short_tmr     = '0;
      long_tmr      = '0;
      hold_tmr      = '0;
      lock_flag     = 1'b0;
      tick_results_q.delete();
      fails         = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SHORT_WIN: cfg.short_win = cfg_data_i[ShortWinW-1:0];
          CFG_LONG_WIN:  cfg.long_win  = cfg_data_i[LongWinW-1:0];
          CFG_HOLD:      cfg.hold      = cfg_data_i[HoldW-1:0];
          CFG_STALL_LIM: cfg.stall_lim = cfg_data_i[CntW-1:0];
          CFG_LOCK_LIM:  cfg.lock_lim  = cfg_data_i[CntW-1:0];
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (tick_results_q.size() == 0) begin
          $error("result word with no tick waiting for it");
          fails++;
        end else begin
          want = tick_results_q.pop_front();
          if (lock_out_i !== want.lock) begin
            $error("lock_out: expected %0d, got %0d", want.lock, lock_out_i);
            fails++;
          end
          if (permanent_out_i !== want.perm) begin
            $error("permanent_out: expected %0d, got %0d", want.perm, permanent_out_i);
            fails++;
          end
          if (stall_events_i !== want.stall_events) begin
            $error("stall_events: expected %0d, got %0d", want.stall_events, stall_events_i);
            fails++;
          end
          if (lock_events_i !== want.lock_events) begin
            $error("lock_events: expected %0d, got %0d", want.lock_events, lock_events_i);
            fails++;
          end
        end
      end

      if (in_valid_i && in_ready_i) tick_results_q.push_back(advance_tick(stall_active_i));
    end
    fail_count_o <= fails;
    pending_o    <= tick_results_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// top of the stall_lock_escalation testbench: clock, reset, tick and config stimulus,
// result-side back-pressure and the verdict; depends on sle_pkg, stall_lock_escalation and sle_checker
module testbench;
  import sle_pkg::*;

  localparam int unsigned NumPhases    = 10;
  localparam int unsigned PhaseTicks   = 140;
  localparam int unsigned SqueezePhase = 4;
  localparam int unsigned SqueezeLen   = 50;
  localparam int unsigned CycleLimit   = 200000;

  typedef enum logic [1:0] {
    RUN_TOGGLE,
    RUN_HIGH,
    RUN_LOW,
    RUN_NOISE
  } run_e;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i     = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic                stall_active_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic                lock_out_o;
  logic                permanent_out_o;
  logic [CntW-1:0]     stall_events_o;
  logic [CntW-1:0]     lock_events_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned phase_no = 0;
  bit          quiet    = 1'b0;
  int unsigned cycles   = 0;

  always #10 clk_i = ~clk_i;

  stall_lock_escalation u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .stall_active_i  (stall_active_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .lock_out_o      (lock_out_o),
    .permanent_out_o (permanent_out_o),
    .stall_events_o  (stall_events_o),
    .lock_events_o   (lock_events_o)
  );

  sle_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .stall_active_i  (stall_active_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .lock_out_i      (lock_out_o),
    .permanent_out_i (permanent_out_o),
    .stall_events_i  (stall_events_o),
    .lock_events_i   (lock_events_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // result side: random stall bursts, one long hold-off so the block backs up
  initial begin
    int unsigned hold_left;
    bit          squeezed;
    hold_left = 0;
    squeezed  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!squeezed && phase_no == SqueezePhase) begin
        squeezed    = 1'b1;
        hold_left   = SqueezeLen;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        hold_left   = $urandom_range(0, 5);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // offer one tick word and hold it until taken, then maybe go quiet for a burst
  task automatic send_tick(input logic stall);
    in_valid_i     <= 1'b1;
    stall_active_i <= stall;
    do @(posedge clk_i); while (!in_ready_o);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // upper data bits beyond the register width carry junk
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val,
                           input int unsigned w);
    logic [CfgDataW-1:0] mask;
    mask = (w >= CfgDataW) ? '1 : ((CfgDataW'(1) << w) - CfgDataW'(1));
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= (CfgDataW'($urandom) & ~mask) | (val & mask);
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic write_settings(input cfg_t c);
    write_reg(CFG_SHORT_WIN, CfgDataW'(c.short_win), ShortWinW);
    write_reg(CFG_LONG_WIN, CfgDataW'(c.long_win), LongWinW);
    write_reg(CFG_HOLD, CfgDataW'(c.hold), HoldW);
    write_reg(CFG_STALL_LIM, CfgDataW'(c.stall_lim), CntW);
    write_reg(CFG_LOCK_LIM, CfgDataW'(c.lock_lim), CntW);
    // index past the register map, should be dropped
    write_reg(CfgIdxW'(CFG_LOCK_LIM) + CfgIdxW'($urandom_range(1, 3)),
              CfgDataW'($urandom), CfgDataW);
    cfg_valid_i <= 1'b0;
  endtask

  // stop offering and wait until every result word is back, plus a little slack
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // mostly edge trains and steady runs, the rest noise
  task automatic run_random(input int unsigned n);
    int unsigned sent;
    int unsigned len;
    int unsigned k;
    int unsigned pick;
    run_e        mode;
    logic        s;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 9);
      mode = (pick < 6) ? RUN_TOGGLE : (pick == 6) ? RUN_HIGH : (pick == 7) ? RUN_LOW : RUN_NOISE;
      // long low runs let the windows and the hold time run out
      len = (mode == RUN_LOW) ? $urandom_range(1, 50) : $urandom_range(1, 16);
      for (k = 0; k < len && sent < n; k++) begin
        case (mode)
          RUN_HIGH:  s = 1'b1;
          RUN_LOW:   s = 1'b0;
          RUN_NOISE: s = 1'($urandom_range(0, 1));
          default:   s = k[0];
        endcase
        send_tick(s);
        sent++;
      end
    end
  endtask

  initial begin
    cfg_t        c;
    int unsigned p;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: fewer stall rises than the stall limit, so no lock and the long-window and hold timers never load
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    drain();

    // short windows: three locks in a row reach permanent lock, then frozen ticks
    c.short_win = ShortWinW'(20);
    c.long_win  = LongWinW'(40);
    c.hold      = HoldW'(5);
    c.stall_lim = CntW'(3);
    c.lock_lim  = CntW'(3);
    write_settings(c);
    repeat (9) begin
      send_tick(1'b0);
      send_tick(1'b1);
    end
    send_tick(1'b1);
    send_tick(1'b0);
    drain();

    for (p = 0; p < NumPhases; p++) begin
      c.short_win = ShortWinW'($urandom_range(0, 40));
      c.long_win  = LongWinW'($urandom_range(0, 150));
      c.hold      = HoldW'($urandom_range(0, 30));
      c.stall_lim = CntW'($urandom_range(1, 5));
      c.lock_lim  = CntW'($urandom_range(1, 14));
      // zero windows expire in the same tick
      if (p == 1) begin
        c.short_win = '0;
        c.long_win  = '0;
        c.hold      = '0;
      end
      // zero stall limit: a lock event on every live tick
      if (p == 2) c.stall_lim = '0;
      if (p == 3) begin
        c.stall_lim = CntW'(1);
        c.lock_lim  = CntW'(1);
      end
      if (p == 5) begin
        c.short_win = ShortWinW'(200);
        c.stall_lim = CntMax;
      end
      // widest settings late, since their timers outlast the rest of the run
      if (p == NumPhases - 2) c = '1;
      // zero lock limit: permanent from the first tick
      if (p == NumPhases - 1) c.lock_lim = '0;
      write_settings(c);
      phase_no <= p;
      if (p == NumPhases - 1) quiet <= 1'b1;
      run_random(PhaseTicks);
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
